// File: rtl/bitplane_rle_compressor_assert.svh
// Assertion macros shared by the bitplane run-length compressor modules
`ifndef BITPLANE_RLE_COMPRESSOR_ASSERT_SVH
`define BITPLANE_RLE_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define BRLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define BRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/brle_pkg.sv
// Shared types, constants and cursor helpers of the bitplane run-length compressor
package brle_pkg;

	localparam int BUFFER_BYTES = 8192;
	localparam int CURSOR_SLACK = 256;
	localparam int OFF_W = $clog2(BUFFER_BYTES);
	localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
	localparam int CUR_W = $clog2(BUFFER_BYTES + CURSOR_SLACK + 1);

	localparam logic [CUR_W-1:0] BUF_LIMIT = CUR_W'(BUFFER_BYTES);
	localparam logic [CUR_W-1:0] CURSOR_CAP = CUR_W'(BUFFER_BYTES + CURSOR_SLACK);

	// Block limits: a block holds at most 128 bytes
	localparam logic [7:0] BLOCK_LAST = 8'd127;
	localparam logic [7:0] RUN_FULL_HDR = 8'h80;
	localparam logic [CUR_W-1:0] PATCH_DIST = CUR_W'(129);

	// Threshold register
	localparam int THR_W = 5;
	localparam logic [THR_W-1:0] THR_RESET = 5'd2;
	localparam logic [THR_W-1:0] THR_MIN = 5'd1;
	localparam logic [THR_W-1:0] THR_MAX = 5'd16;

	// Lookahead states
	localparam logic [1:0] HELD_RESOLVED = 2'd3;
	localparam logic [1:0] HELD_FULL = 2'd2;

	// Queue sizes
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Work item handed from the front to the back
	typedef struct packed {
		logic fof;
		logic start;
		logic start_run;
		logic [1:0] nbytes;
		logic [2:0][7:0] bytes;
		logic flush;
	} entry_t;

	// One result word
	typedef struct packed {
		logic [OFF_W-1:0] write_offset;
		logic [7:0] write_byte;
		logic write_valid;
		logic plane_done;
		logic [LEN_W-1:0] total_length;
		logic last_result;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EMIT
	} back_state_t;

	// Saturating cursor advance
	function automatic logic [CUR_W-1:0] f_adv(input logic [CUR_W-1:0] c, input logic [1:0] n);
		logic [CUR_W:0] sum;
		sum = {1'b0, c} + {{(CUR_W-1){1'b0}}, n};
		if (sum > {1'b0, CURSOR_CAP}) begin
			return CURSOR_CAP;
		end
		return sum[CUR_W-1:0];
	endfunction

	// Rewind, floored at zero
	function automatic logic [CUR_W-1:0] f_rew(input logic [CUR_W-1:0] c,
			input logic [CUR_W-1:0] n);
		return (c > n) ? c - n : '0;
	endfunction

	function automatic logic f_in(input logic [CUR_W-1:0] pos);
		return pos < BUF_LIMIT;
	endfunction

	function automatic res_t f_wr(input logic [CUR_W-1:0] pos, input logic [7:0] val);
		res_t r;
		r = '0;
		r.write_offset = pos[OFF_W-1:0];
		r.write_byte = val;
		r.write_valid = 1'b1;
		return r;
	endfunction

	function automatic res_t f_done(input logic [CUR_W-1:0] c);
		res_t r;
		r = '0;
		r.plane_done = 1'b1;
		r.total_length = (c < BUF_LIMIT) ? LEN_W'(c) : LEN_W'(BUF_LIMIT);
		return r;
	endfunction

endpackage

// File: rtl/brle_cmd_queue.sv
// Four-entry queue of work items between the front and the back
`include "bitplane_rle_compressor_assert.svh"

module brle_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  brle_pkg::entry_t  din,
	input  logic              pop,
	output brle_pkg::entry_t  dout,
	output logic              empty,
	output logic              full
);

	brle_pkg::entry_t mem_q [brle_pkg::QDEPTH];
	logic [brle_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [brle_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [brle_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == brle_pkg::QCNT_W'(brle_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + brle_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + brle_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + brle_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - brle_pkg::QCNT_W'(1);
			end
		end
	end

	`BRLE_ASSERT_NEXT(a_cq_fill, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + brle_pkg::QCNT_W'(1), "cmd queue count did not rise on push")

endmodule

// File: rtl/brle_res_queue.sv
// Four-entry result queue facing the output side
`include "bitplane_rle_compressor_assert.svh"

module brle_res_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  brle_pkg::res_t  din,
	input  logic            pop,
	output brle_pkg::res_t  dout,
	output logic            empty,
	output logic            full
);

	brle_pkg::res_t mem_q [brle_pkg::QDEPTH];
	logic [brle_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [brle_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [brle_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == brle_pkg::QCNT_W'(brle_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + brle_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + brle_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + brle_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - brle_pkg::QCNT_W'(1);
			end
		end
	end

	`BRLE_ASSERT_NEXT(a_rq_drain, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - brle_pkg::QCNT_W'(1), "result queue count did not fall on pop")

endmodule

// File: rtl/brle_front.sv
// Front end: lookahead hold of the first plane bytes and work item build
`include "bitplane_rle_compressor_assert.svh"

module brle_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        data_byte,
	input  logic              last_of_plane,
	input  logic              first_of_frame,
	input  logic              cq_full,
	output logic              cq_push,
	output brle_pkg::entry_t  cq_data
);

	logic [1:0] held_q;
	logic [7:0] hb0_q;
	logic [7:0] hb1_q;
	logic [1:0] held_d;
	logic accept;

	assign accept = push && !cq_full;
	assign cq_push = accept;

	// Classify the word against the lookahead state
	always_comb begin
		cq_data = '0;
		held_d = held_q;
		cq_data.fof = first_of_frame;
		cq_data.flush = last_of_plane;
		if (held_q == brle_pkg::HELD_RESOLVED) begin
			cq_data.nbytes = 2'd1;
			cq_data.bytes[0] = data_byte;
		end else if (held_q == brle_pkg::HELD_FULL || last_of_plane) begin
			cq_data.start = 1'b1;
			cq_data.nbytes = held_q + 2'd1;
			case (held_q)
				2'd0: begin
					cq_data.bytes[0] = data_byte;
				end
				2'd1: begin
					cq_data.bytes[0] = hb0_q;
					cq_data.bytes[1] = data_byte;
				end
				default: begin
					cq_data.bytes[0] = hb0_q;
					cq_data.bytes[1] = hb1_q;
					cq_data.bytes[2] = data_byte;
				end
			endcase
			cq_data.start_run = (held_q == brle_pkg::HELD_FULL) && (hb0_q == hb1_q)
				&& (hb0_q == data_byte);
			held_d = brle_pkg::HELD_RESOLVED;
		end else begin
			held_d = held_q + 2'd1;
		end
		if (last_of_plane) begin
			held_d = '0;
		end
	end

	// Lookahead count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

	// Held bytes
	always_ff @(posedge clk) begin
		if (accept && !last_of_plane && held_q == 2'd0) begin
			hb0_q <= data_byte;
		end
		if (accept && !last_of_plane && held_q == 2'd1) begin
			hb1_q <= data_byte;
		end
	end

	`BRLE_ASSERT_NEXT(a_plane_end_clears, clk, arst_n, accept && last_of_plane, held_q == 2'd0, "lookahead not cleared at plane end")

endmodule

// File: rtl/brle_back.sv
// Back end: encoder state, per-byte decision and one buffer write per cycle while the result queue has room
`include "bitplane_rle_compressor_assert.svh"

module brle_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [brle_pkg::THR_W-1:0]    thr,
	input  brle_pkg::entry_t              cq_head,
	input  logic                          cq_empty,
	output logic                          cq_pop,
	input  logic                          rq_full,
	output logic                          rq_push,
	output brle_pkg::res_t                rq_data
);

	localparam int CW = brle_pkg::CUR_W;

	brle_pkg::back_state_t state_q;
	brle_pkg::back_state_t state_d;

	// Encoder state
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] cur_d;
	logic in_run_q;
	logic run_d;
	logic [7:0] rv_q;
	logic [7:0] rv_d;
	logic [7:0] bc_q;
	logic [7:0] bc_d;
	logic [4:0] streak_q;
	logic [4:0] stk_d;

	// Current item and write slots
	brle_pkg::entry_t ent_q;
	brle_pkg::entry_t ent_d;
	logic [1:0] idx_q;
	logic [1:0] idx_d;
	logic fl_q;
	logic fl_d;
	brle_pkg::res_t slot_q [3];
	brle_pkg::res_t slot_d [3];
	logic [2:0] mask_q;
	logic [2:0] mask_d;
	brle_pkg::res_t hold_q;
	brle_pkg::res_t hold_d;
	logic hold_valid_q;
	logic hv_d;

	// Decision temporaries
	logic [7:0] b;
	logic [CW-1:0] c;
	logic [CW-1:0] c0;
	logic [CW-1:0] c1;
	logic [CW-1:0] c2;
	logic [CW-1:0] hdr_dist;
	logic [CW-1:0] amt;
	logic [CW-1:0] pos;
	logic [7:0] thr8;
	logic [5:0] stk_inc;
	logic [1:0] sel;

	always_comb begin
		state_d = state_q;
		ent_d = ent_q;
		idx_d = idx_q;
		fl_d = fl_q;
		cur_d = cursor_q;
		run_d = in_run_q;
		rv_d = rv_q;
		bc_d = bc_q;
		stk_d = streak_q;
		slot_d = slot_q;
		mask_d = mask_q;
		hold_d = hold_q;
		hv_d = hold_valid_q;
		cq_pop = 1'b0;
		rq_push = 1'b0;
		rq_data = hold_q;
		rq_data.last_result = 1'b0;
		c = cursor_q;
		c0 = '0;
		c1 = '0;
		c2 = '0;
		hdr_dist = CW'(bc_q) + CW'(1);
		amt = '0;
		pos = '0;
		thr8 = 8'(thr);
		stk_inc = {1'b0, streak_q} + 6'd1;
		sel = mask_q[0] ? 2'd0 : (mask_q[1] ? 2'd1 : 2'd2);
		case (idx_q)
			2'd0: b = ent_q.bytes[0];
			2'd1: b = ent_q.bytes[1];
			default: b = ent_q.bytes[2];
		endcase

		case (state_q)
			// Take the next item; cursor clear and plane start happen here
			brle_pkg::ST_IDLE: begin
				if (!cq_empty) begin
					cq_pop = 1'b1;
					ent_d = cq_head;
					idx_d = '0;
					fl_d = 1'b0;
					c0 = cq_head.fof ? '0 : cursor_q;
					cur_d = c0;
					if (cq_head.start) begin
						run_d = cq_head.start_run;
						rv_d = cq_head.start_run ? cq_head.bytes[0] : 8'd0;
						bc_d = '0;
						stk_d = '0;
						if (!cq_head.start_run) begin
							cur_d = brle_pkg::f_adv(c0, 2'd1);
						end
					end
					state_d = brle_pkg::ST_STEP;
				end
			end

			// One byte decision, the flush, or close of the item
			brle_pkg::ST_STEP: begin
				if (idx_q < ent_q.nbytes) begin
					idx_d = idx_q + 2'd1;
					mask_d = '0;
					state_d = brle_pkg::ST_EMIT;
					if (in_run_q) begin
						if (b == rv_q) begin
							if (bc_q >= brle_pkg::BLOCK_LAST) begin
								slot_d[0] = brle_pkg::f_wr(c, brle_pkg::RUN_FULL_HDR);
								slot_d[1] = brle_pkg::f_wr(c + CW'(1), rv_q);
								mask_d[0] = brle_pkg::f_in(c);
								mask_d[1] = brle_pkg::f_in(c + CW'(1));
								cur_d = brle_pkg::f_adv(c, 2'd2);
								bc_d = '0;
							end else begin
								bc_d = bc_q + 8'd1;
							end
						end else begin
							// Close the run, then open a literal block with this byte
							c1 = c;
							if (bc_q != 8'd0) begin
								slot_d[0] = brle_pkg::f_wr(c, 8'd0 - bc_q);
								slot_d[1] = brle_pkg::f_wr(c + CW'(1), rv_q);
								mask_d[0] = brle_pkg::f_in(c);
								mask_d[1] = brle_pkg::f_in(c + CW'(1));
								c1 = brle_pkg::f_adv(c, 2'd2);
							end
							slot_d[2] = brle_pkg::f_wr(c1 + CW'(1), b);
							mask_d[2] = brle_pkg::f_in(c1 + CW'(1));
							cur_d = brle_pkg::f_adv(c1, 2'd2);
							run_d = 1'b0;
							bc_d = 8'd1;
							rv_d = b;
							stk_d = 5'd1;
						end
					end else if (b == rv_q && stk_inc > {1'b0, thr}) begin
						// Too many repeats: pull them out of the block and start a run
						stk_d = stk_inc[4:0];
						pos = c - hdr_dist;
						if (bc_q > thr8) begin
							slot_d[0] = brle_pkg::f_wr(pos, bc_q - thr8 - 8'd1);
							mask_d[0] = (c >= hdr_dist) && brle_pkg::f_in(pos);
							amt = CW'(thr);
						end else begin
							amt = CW'(thr) + CW'(1);
						end
						cur_d = brle_pkg::f_rew(c, amt);
						bc_d = thr8 + 8'd1;
						run_d = 1'b1;
					end else begin
						// Literal byte
						if (b == rv_q) begin
							stk_d = stk_inc[4:0];
						end else begin
							rv_d = b;
							stk_d = 5'd1;
						end
						slot_d[0] = brle_pkg::f_wr(c, b);
						mask_d[0] = brle_pkg::f_in(c);
						c2 = brle_pkg::f_adv(c, 2'd1);
						pos = c2 - brle_pkg::PATCH_DIST;
						if (bc_q >= brle_pkg::BLOCK_LAST) begin
							slot_d[1] = brle_pkg::f_wr(pos, brle_pkg::BLOCK_LAST);
							mask_d[1] = (c2 >= brle_pkg::PATCH_DIST) && brle_pkg::f_in(pos);
							bc_d = '0;
							stk_d = '0;
							cur_d = brle_pkg::f_adv(c2, 2'd1);
						end else begin
							bc_d = bc_q + 8'd1;
							cur_d = c2;
						end
					end
				end else if (ent_q.flush && !fl_q) begin
					// Plane end: close the open block and report the length
					fl_d = 1'b1;
					mask_d = '0;
					c1 = c;
					pos = c - hdr_dist;
					if (in_run_q) begin
						if (bc_q != 8'd0) begin
							slot_d[0] = brle_pkg::f_wr(c, 8'd0 - bc_q);
							slot_d[1] = brle_pkg::f_wr(c + CW'(1), rv_q);
							mask_d[0] = brle_pkg::f_in(c);
							mask_d[1] = brle_pkg::f_in(c + CW'(1));
							c1 = brle_pkg::f_adv(c, 2'd2);
						end
					end else if (bc_q != 8'd0) begin
						slot_d[0] = brle_pkg::f_wr(pos, bc_q - 8'd1);
						mask_d[0] = (c >= hdr_dist) && brle_pkg::f_in(pos);
					end else begin
						c1 = brle_pkg::f_rew(c, CW'(1));
					end
					slot_d[2] = brle_pkg::f_done(c1);
					mask_d[2] = 1'b1;
					cur_d = c1;
					run_d = 1'b0;
					rv_d = '0;
					bc_d = '0;
					stk_d = '0;
					state_d = brle_pkg::ST_EMIT;
				end else if (!hold_valid_q) begin
					state_d = brle_pkg::ST_IDLE;
				end else if (!rq_full) begin
					// Release the held word marked as the item's last
					rq_push = 1'b1;
					rq_data.last_result = 1'b1;
					hv_d = 1'b0;
					state_d = brle_pkg::ST_IDLE;
				end
			end

			// One write per cycle if the queue has room; newest word held until its successor
			brle_pkg::ST_EMIT: begin
				if (mask_q == 3'b000) begin
					state_d = brle_pkg::ST_STEP;
				end else if (!hold_valid_q || !rq_full) begin
					rq_push = hold_valid_q;
					hold_d = slot_q[sel];
					hv_d = 1'b1;
					mask_d[sel] = 1'b0;
					if (mask_d == 3'b000) begin
						state_d = brle_pkg::ST_STEP;
					end
				end
			end

			default: begin
				state_d = brle_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			in_run_q <= 1'b0;
			rv_q <= '0;
			bc_q <= '0;
			streak_q <= '0;
			idx_q <= '0;
			fl_q <= 1'b0;
			mask_q <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			cursor_q <= cur_d;
			in_run_q <= run_d;
			rv_q <= rv_d;
			bc_q <= bc_d;
			streak_q <= stk_d;
			idx_q <= idx_d;
			fl_q <= fl_d;
			mask_q <= mask_d;
			hold_valid_q <= hv_d;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		ent_q <= ent_d;
		slot_q <= slot_d;
		hold_q <= hold_d;
	end

	`BRLE_ASSERT_NEXT(a_fof_clears_cursor, clk, arst_n, state_q == brle_pkg::ST_IDLE && !cq_empty && cq_head.fof && !cq_head.start, cursor_q == '0, "frame start did not clear the write cursor")
	`BRLE_ASSERT_NOW(a_push_needs_hold, clk, arst_n, rq_push, hold_valid_q && !rq_full, "result pushed without a held word or into a full queue")

endmodule

// File: rtl/bitplane_rle_compressor.sv
// Bitplane run-length compressor (PackBits style), top level
//
// Bytes of a bitplane go in through a queue-style port (push/full) and come out as
// addressed output-buffer writes, header back-patches and one plane-done word with the
// compressed length (empty/pop). The first two bytes of each plane are held as lookahead
// and produce nothing until the third byte or the plane end arrives. A front end
// classifies each byte into a work item and places it in a four-entry queue; the back
// end sequencer carries out one item at a time: it loads the item, makes a decision for
// each byte, issues the buffer writes one by one (a byte with no write still passes
// through the emit state), and closes the item. The plane start with its lookahead
// bytes and the plane flush add a decision and their writes each. A four-word result
// queue lets the back end run on while the consumer stalls. repeat_threshold sits at
// byte address 0 of the APB port; values 0 and 17..31 act as 1 and 16. There is no
// clearing pass after reset.

module bitplane_rle_compressor (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input side
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          last_of_plane,
	input  logic                          first_of_frame,
	// Result side
	output logic                          empty,
	input  logic                          pop,
	output logic [brle_pkg::OFF_W-1:0]    write_offset,
	output logic [7:0]                    write_byte,
	output logic                          write_valid,
	output logic                          plane_done,
	output logic [brle_pkg::LEN_W-1:0]    total_length,
	output logic                          last_result,
	// Configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [brle_pkg::THR_W-1:0] cfg_thr_q;
	logic [brle_pkg::THR_W-1:0] thr_eff;
	logic cq_full;
	logic cq_empty;
	logic cq_push;
	logic cq_pop;
	brle_pkg::entry_t cq_data;
	brle_pkg::entry_t cq_head;
	logic rq_full;
	logic rq_push;
	brle_pkg::res_t rq_data;
	brle_pkg::res_t rq_head;
	logic reg_hit;

	// Register file
	assign pready = 1'b1;
	assign reg_hit = (paddr[2] == 1'b0);
	assign prdata = reg_hit ? {{(32 - brle_pkg::THR_W){1'b0}}, cfg_thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_thr_q <= brle_pkg::THR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			cfg_thr_q <= pwdata[brle_pkg::THR_W-1:0];
		end
	end

	// Clamp the threshold into its working range
	always_comb begin
		if (cfg_thr_q < brle_pkg::THR_MIN) begin
			thr_eff = brle_pkg::THR_MIN;
		end else if (cfg_thr_q > brle_pkg::THR_MAX) begin
			thr_eff = brle_pkg::THR_MAX;
		end else begin
			thr_eff = cfg_thr_q;
		end
	end

	assign full = cq_full;

	brle_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.data_byte     (data_byte),
		.last_of_plane (last_of_plane),
		.first_of_frame(first_of_frame),
		.cq_full       (cq_full),
		.cq_push       (cq_push),
		.cq_data       (cq_data)
	);

	brle_cmd_queue u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.din   (cq_data),
		.pop   (cq_pop),
		.dout  (cq_head),
		.empty (cq_empty),
		.full  (cq_full)
	);

	brle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.thr     (thr_eff),
		.cq_head (cq_head),
		.cq_empty(cq_empty),
		.cq_pop  (cq_pop),
		.rq_full (rq_full),
		.rq_push (rq_push),
		.rq_data (rq_data)
	);

	brle_res_queue u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push),
		.din   (rq_data),
		.pop   (pop),
		.dout  (rq_head),
		.empty (empty),
		.full  (rq_full)
	);

	// Result fields from the queue head
	assign write_offset = rq_head.write_offset;
	assign write_byte = rq_head.write_byte;
	assign write_valid = rq_head.write_valid;
	assign plane_done = rq_head.plane_done;
	assign total_length = rq_head.total_length;
	assign last_result = rq_head.last_result;

endmodule

// File: tb/bitplane_rle_compressor_test.sv
// Self-checking testbench for the bitplane run-length compressor
`timescale 1ns / 100ps

module bitplane_rle_compressor_test;

	localparam logic [2:0] THR_ADDR = 3'd0;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned MAX_REPORTS = 200;

	// PackBits encoder prediction and the words it still expects
	class packbits_checker;
		logic [4:0] thr_reg;
		logic [7:0] held [2];
		int unsigned held_n;
		bit in_run;
		logic [7:0] run_val;
		int unsigned blk_cnt;
		int unsigned streak;
		int unsigned cursor;
		brle_pkg::res_t words_now [$];
		brle_pkg::res_t expected_words [$];
		int unsigned errors;

		function new();
			thr_reg = brle_pkg::THR_RESET;
			held[0] = '0;
			held[1] = '0;
			held_n = 0;
			in_run = 0;
			run_val = '0;
			blk_cnt = 0;
			streak = 0;
			cursor = 0;
			errors = 0;
		endfunction

		function void set_threshold(logic [4:0] v);
			thr_reg = v;
		endfunction

		// out-of-range register values clamp to 1 and 16
		function int unsigned eff_thr();
			if (thr_reg == 0) return 1;
			if (thr_reg > 16) return 16;
			return int'(thr_reg);
		endfunction

		function void put_write(int unsigned pos, int unsigned val);
			brle_pkg::res_t w;
			if (pos < brle_pkg::BUFFER_BYTES) begin
				w = '0;
				w.write_offset = pos[brle_pkg::OFF_W-1:0];
				w.write_byte = val[7:0];
				w.write_valid = 1'b1;
				words_now.push_back(w);
			end
		endfunction

		// header back-patch; dropped when it would land below zero
		function void put_back(int unsigned back_dist, int unsigned val);
			if (cursor >= back_dist) put_write(cursor - back_dist, val);
		endfunction

		function void advance(int unsigned n);
			cursor = cursor + n;
			if (cursor > brle_pkg::BUFFER_BYTES + brle_pkg::CURSOR_SLACK)
				cursor = brle_pkg::BUFFER_BYTES + brle_pkg::CURSOR_SLACK;
		endfunction

		function void rewind(int unsigned n);
			cursor = (cursor > n) ? cursor - n : 0;
		endfunction

		// one byte once the lookahead is resolved
		function void take_byte(logic [7:0] b);
			int unsigned t;
			t = eff_thr();
			if (in_run) begin
				if (b == run_val) begin
					blk_cnt++;
					if (blk_cnt >= 128) begin
						put_write(cursor, 8'h80);
						put_write(cursor + 1, run_val);
						advance(2);
						blk_cnt = 0;
					end
				end else begin
					if (blk_cnt > 0) begin
						put_write(cursor, (256 - blk_cnt) & 255);
						put_write(cursor + 1, run_val);
						advance(2);
					end
					in_run = 0;
					blk_cnt = 1;
					run_val = b;
					streak = 1;
					put_write(cursor + 1, b);
					advance(2);
				end
				return;
			end
			if (b == run_val) begin
				streak++;
				if (streak > t) begin
					// pull the trailing repeats back out and start a run
					if (blk_cnt > t) put_back(blk_cnt + 1, blk_cnt - t - 1);
					else rewind(1);
					rewind(t);
					blk_cnt = t + 1;
					in_run = 1;
					return;
				end
			end else begin
				run_val = b;
				streak = 1;
			end
			put_write(cursor, b);
			advance(1);
			blk_cnt++;
			// full literal block: patch header, reserve the next slot
			if (blk_cnt >= 128) begin
				put_back(129, 127);
				blk_cnt = 0;
				streak = 0;
				advance(1);
			end
		endfunction

		function void open_plane(logic [2:0][7:0] seq, int unsigned len);
			if (len == 3 && seq[0] == seq[1] && seq[0] == seq[2]) begin
				in_run = 1;
				run_val = seq[0];
			end else begin
				in_run = 0;
				run_val = '0;
				advance(1);
			end
			blk_cnt = 0;
			streak = 0;
			held_n = 3;
			for (int i = 0; i < len; i++) take_byte(seq[i]);
		endfunction

		function void close_plane();
			brle_pkg::res_t w;
			if (in_run) begin
				if (blk_cnt > 0) begin
					put_write(cursor, (256 - blk_cnt) & 255);
					put_write(cursor + 1, run_val);
					advance(2);
				end
			end else begin
				if (blk_cnt > 0) put_back(blk_cnt + 1, blk_cnt - 1);
				else rewind(1);
			end
			w = '0;
			w.plane_done = 1'b1;
			w.total_length = (cursor < brle_pkg::BUFFER_BYTES) ?
				cursor[brle_pkg::LEN_W-1:0] : brle_pkg::LEN_W'(brle_pkg::BUFFER_BYTES);
			words_now.push_back(w);
			held_n = 0;
			in_run = 0;
			run_val = '0;
			blk_cnt = 0;
			streak = 0;
		endfunction

		// accepted input byte: work out the words it causes
		function void encode_byte(logic [7:0] b, bit is_last, bit fof);
			logic [2:0][7:0] seq;
			brle_pkg::res_t w;
			words_now.delete();
			if (fof) cursor = 0;
			if (held_n >= 3) begin
				take_byte(b);
			end else if (held_n == 2 || is_last) begin
				seq = '0;
				seq[0] = held[0];
				seq[1] = held[1];
				seq[held_n] = b;
				open_plane(seq, held_n + 1);
			end else begin
				held[held_n & 1] = b;
				held_n++;
			end
			if (is_last) close_plane();
			if (words_now.size() > 0) begin
				w = words_now.pop_back();
				w.last_result = 1'b1;
				words_now.push_back(w);
			end
			foreach (words_now[i]) expected_words.push_back(words_now[i]);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		// accepted result word against the oldest expectation
		function void compare_word(brle_pkg::res_t got);
			brle_pkg::res_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: word with nothing expected: offset %0d byte %0d valid %0b done %0b",
						$time, got.write_offset, got.write_byte, got.write_valid, got.plane_done);
				return;
			end
			want = expected_words.pop_front();
			check_field("write_offset", 16'(want.write_offset), 16'(got.write_offset));
			check_field("write_byte", 16'(want.write_byte), 16'(got.write_byte));
			check_field("write_valid", 16'(want.write_valid), 16'(got.write_valid));
			check_field("plane_done", 16'(want.plane_done), 16'(got.plane_done));
			check_field("total_length", 16'(want.total_length), 16'(got.total_length));
			check_field("last_result", 16'(want.last_result), 16'(got.last_result));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] data_byte;
	logic last_of_plane;
	logic first_of_frame;
	logic empty;
	logic pop;
	logic [brle_pkg::OFF_W-1:0] write_offset;
	logic [7:0] write_byte;
	logic write_valid;
	logic plane_done;
	logic [brle_pkg::LEN_W-1:0] total_length;
	logic last_result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	packbits_checker sb = new();

	// byte stream generator state
	int unsigned plane_left;
	int unsigned seg_left;
	bit seg_run;
	logic [7:0] seg_val;
	bit long_plane;
	bit want_long;
	bit send_idle;
	bit hold_request;

	bitplane_rle_compressor uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_of_plane(last_of_plane),
		.first_of_frame(first_of_frame),
		.empty(empty),
		.pop(pop),
		.write_offset(write_offset),
		.write_byte(write_byte),
		.write_valid(write_valid),
		.plane_done(plane_done),
		.total_length(total_length),
		.last_result(last_result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// planes built from runs and literal stretches, with stray frame starts
	function automatic void gen_item(output logic [7:0] b, output bit is_last, output bit fof);
		int unsigned r;
		bit opening;
		opening = (plane_left == 0);
		if (opening) begin
			r = $urandom_range(0, 99);
			long_plane = want_long;
			want_long = 0;
			if (long_plane) plane_left = 280;
			else if (r < 70) plane_left = $urandom_range(1, 24);
			else if (r < 96) plane_left = $urandom_range(25, 90);
			else plane_left = $urandom_range(130, 200);
			seg_left = 0;
			seg_run = 1;
			send_idle = ($urandom_range(0, 3) != 0);
		end
		if (seg_left == 0) begin
			if (long_plane) begin
				// a full literal block, then a full run
				seg_run = !seg_run;
				seg_left = seg_run ? $urandom_range(145, 150) : $urandom_range(130, 135);
			end else begin
				seg_run = ($urandom_range(0, 2) == 0);
				if (seg_run)
					seg_left = ($urandom_range(0, 7) == 0) ?
						$urandom_range(60, 140) : $urandom_range(2, 20);
				else
					seg_left = $urandom_range(1, 16);
			end
			seg_val = 8'($urandom);
		end
		if (seg_run || (!long_plane && $urandom_range(0, 3) == 0)) b = seg_val;
		else b = 8'($urandom);
		seg_left--;
		plane_left--;
		is_last = (plane_left == 0);
		fof = opening ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 59) == 0);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit is_last, input bit fof);
		int unsigned gap;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_of_plane <= is_last;
		first_of_frame <= fof;
		do @(posedge clk); while (full);
		sb.encode_byte(b, is_last, fof);
	endtask

	task automatic send_random(input int unsigned count);
		logic [7:0] b;
		bit is_last;
		bit fof;
		repeat (count) begin
			gen_item(b, is_last, fof);
			send_byte(b, is_last, fof);
		end
	endtask

	// one APB transfer, then return the bus to idle
	task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_threshold_reg(input logic [4:0] want);
		logic [31:0] rd;
		apb_access(1'b0, THR_ADDR, '0, rd);
		if (rd !== {27'd0, want}) begin
			sb.errors++;
			$display("%0t: repeat_threshold read expected %0d, got %0d", $time, want, rd);
		end
	endtask

	task automatic program_threshold(input logic [4:0] v);
		logic [31:0] rd;
		apb_access(1'b1, THR_ADDR, {27'd0, v}, rd);
		sb.set_threshold(v);
		check_threshold_reg(v);
	endtask

	// wait for every expected word, then let queued no-output bytes finish
	task automatic settle();
		push <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin : result_side
		int unsigned stall_left;
		int unsigned taken;
		bit stall_mode;
		bit took;
		brle_pkg::res_t got;
		pop <= 1'b0;
		stall_left = 0;
		taken = 0;
		stall_mode = 1;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			took = pop && !empty;
			if (took) begin
				got.write_offset = write_offset;
				got.write_byte = write_byte;
				got.write_valid = write_valid;
				got.plane_done = plane_done;
				got.total_length = total_length;
				got.last_result = last_result;
				sb.compare_word(got);
				taken++;
				if (taken % 40 == 0) stall_mode = ($urandom_range(0, 2) != 0);
				if (stall_mode) stall_left = pick_gap();
			end
			if (hold_request) begin
				hold_request = 0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no word moved on any port
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || psel) quiet = 0;
			else quiet++;
		end
		$display("bitplane_rle_compressor test failed");
		$finish;
	end

	initial begin : stimulus
		logic [4:0] plan [6];
		logic [7:0] b;
		bit is_last;
		bit fof;
		arst_n <= 1'b0;
		push <= 1'b0;
		data_byte <= '0;
		last_of_plane <= 1'b0;
		first_of_frame <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		plane_left = 0;
		seg_left = 0;
		seg_run = 0;
		seg_val = '0;
		long_plane = 0;
		want_long = 0;
		send_idle = 1;
		hold_request = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_threshold_reg(brle_pkg::THR_RESET);

		// single-byte plane at the bottom value, with a frame start
		send_byte(8'h00, 1, 1);
		// two-byte plane at the top value
		send_byte(8'hFF, 0, 0);
		send_byte(8'hFF, 1, 0);
		// run opening, run end, literal turning into a run
		send_byte(8'hAA, 0, 0);
		send_byte(8'hAA, 0, 0);
		send_byte(8'hAA, 0, 0);
		send_byte(8'hAA, 0, 0);
		send_byte(8'h55, 0, 0);
		send_byte(8'h01, 0, 0);
		send_byte(8'h01, 0, 0);
		send_byte(8'h01, 0, 0);
		send_byte(8'h01, 0, 0);
		send_byte(8'h80, 0, 0);
		send_byte(8'h7F, 1, 0);
		// switch to a run that leaves the literal block empty
		send_byte(8'h33, 0, 0);
		send_byte(8'h33, 0, 0);
		send_byte(8'h33, 0, 0);
		send_byte(8'h44, 0, 0);
		send_byte(8'h44, 0, 0);
		send_byte(8'h44, 0, 0);
		send_byte(8'h44, 0, 0);
		send_byte(8'h44, 1, 0);
		// short plane of two equal bytes
		send_byte(8'h5A, 0, 0);
		send_byte(8'h5A, 1, 0);

		// random phases; a phase may end inside a block
		plan[0] = 5'd1;
		plan[1] = 5'd16;
		plan[2] = 5'd0;
		plan[3] = 5'd31;
		plan[4] = 5'($urandom_range(3, 15));
		plan[5] = 5'd2;
		for (int p = 0; p < 6; p++) begin
			settle();
			program_threshold(plan[p]);
			if (p == 1) hold_request = 1;
			send_random(15);
		end
		while (plane_left != 0) begin
			gen_item(b, is_last, fof);
			send_byte(b, is_last, fof);
		end

		// a full literal block and a full run, with the receiver held off
		settle();
		program_threshold(5'd16);
		hold_request = 1;
		want_long = 1;
		send_random(1);
		while (plane_left != 0) begin
			gen_item(b, is_last, fof);
			send_byte(b, is_last, fof);
		end

		settle();
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("bitplane_rle_compressor test passed");
		else
			$display("bitplane_rle_compressor test failed");
		$finish;
	end

endmodule
